// ===== src/packet_sequence_loss_monitor_defines.svh =====
// Assertion macros shared by the packet sequence loss monitor.
`ifndef PACKET_SEQUENCE_LOSS_MONITOR_DEFINES_SVH
`define PACKET_SEQUENCE_LOSS_MONITOR_DEFINES_SVH

`ifndef ASSERT_OFF

// Same-cycle implication, disabled while reset is held.
`define PSL_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("psl assertion failed");

// Next-cycle implication, disabled while reset is held.
`define PSL_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("psl assertion failed");

`else

`define PSL_ASSERT_NOW(label, clk, rst_n, ante, cons)
`define PSL_ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

// ===== src/psl_pkg.sv =====
// Types and codes shared by the packet sequence loss monitor.
package psl_pkg;

    localparam int CFG_W     = 32;
    localparam int CFG_IDX_W = 2;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_EXPECTED_LENGTH = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MAGIC_VALUE     = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_TIMEOUT_MS      = 2'd2;

    // Configuration reset values
    localparam logic [7:0]  RST_EXPECTED_LENGTH = 8'd8;
    localparam logic [7:0]  RST_MAGIC_VALUE     = 8'd0;
    localparam logic [31:0] RST_TIMEOUT_MS      = 32'd3000;

    // Item opcodes
    localparam logic [1:0] OP_PING  = 2'd0;
    localparam logic [1:0] OP_TICK  = 2'd1;
    localparam logic [1:0] OP_CLEAR = 2'd2;

    // Result status codes
    localparam logic [2:0] ST_NONE      = 3'd0;
    localparam logic [2:0] ST_BAD_LEN   = 3'd1;
    localparam logic [2:0] ST_BAD_MAGIC = 3'd2;
    localparam logic [2:0] ST_ACCEPTED  = 3'd3;
    localparam logic [2:0] ST_LOST      = 3'd4;
    localparam logic [2:0] ST_RESTORED  = 3'd5;

    typedef struct packed {
        logic [1:0]  opcode;
        logic [31:0] now_ms;
        logic [7:0]  msg_length;
        logic [7:0]  magic_byte;
        logic [31:0] sequence_req;
        logic [47:0] source_mac;
    } t_in_item;

    typedef struct packed {
        logic [2:0]  status;
        logic [31:0] gap_count;
        logic [31:0] silence_ms;
        logic [31:0] received_total;
        logic [31:0] missed_total;
        logic [31:0] loss_event_total;
        logic [31:0] latest_sequence;
        logic        link_lost;
        logic        sender_seen;
        logic [47:0] sender_mac;
    } t_out_item;

    typedef struct packed {
        logic [7:0]  expected_length;
        logic [7:0]  magic_value;
        logic [31:0] timeout_ms;
    } t_cfg;

endpackage

// ===== src/psl_in_if.sv =====
// Input channel: one ping, time check or counter reset per transfer.
interface psl_in_if;
    import psl_pkg::*;

    logic     valid;
    logic     ready;
    t_in_item data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// ===== src/psl_out_if.sv =====
// Output channel: one status and statistics record per transfer.
interface psl_out_if;
    import psl_pkg::*;

    logic      valid;
    logic      ready;
    t_out_item data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// ===== src/packet_sequence_loss_monitor.sv =====
// Top level of the packet sequence loss monitor.
//
// Usage
//   i_in carries one item per transfer: a ping packet, a time check or a
//   counter reset, selected by opcode. o_out returns exactly one record per
//   item: a status code and the statistics as they stand after that item.
//   Configuration (expected length, magic byte, timeout) is written through
//   i_cfg_we / i_cfg_idx / i_cfg_wdata while no item is in flight.
// Timing
//   Two register stages: an input register and a result register. A record
//   is offered on o_out from the result register. One item per cycle is
//   sustained while o_out.ready is high; the rate is set by the single
//   evaluation step between the two registers, which reads and updates the
//   monitor state in the same cycle.
// Reset
//   i_rst_n is synchronous and active low. It empties both stages, clears
//   all counters, flags, sequence, time and MAC, and restores configuration
//   defaults.
// Back-pressure
//   While o_out.ready is low a waiting record holds; the input register still
//   takes one more item, after which i_in.ready drops until the record moves.
`include "packet_sequence_loss_monitor_defines.svh"

module packet_sequence_loss_monitor (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    psl_in_if.sink                         i_in,
    psl_out_if.source                      o_out,
    input  logic                           i_cfg_we,
    input  logic [psl_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [psl_pkg::CFG_W-1:0]      i_cfg_wdata
);
    import psl_pkg::*;

    t_cfg      cfg;
    t_out_item result;

    logic      r_in_valid;
    t_in_item  r_in_data;
    logic      r_out_valid;
    t_out_item r_out_data;

    logic      advance;
    logic      in_take;
    logic      step;

    // advance the pipeline whenever the result register is free or draining
    assign advance = !r_out_valid || o_out.ready;
    assign i_in.ready = !r_in_valid || advance;
    assign in_take = i_in.valid && i_in.ready;
    assign step = r_in_valid && advance;

    psl_cfg_regs u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_wdata (i_cfg_wdata),
        .o_cfg       (cfg)
    );

    psl_core u_core (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_step   (step),
        .i_item   (r_in_data),
        .i_cfg    (cfg),
        .o_result (result)
    );

    // input register: hold the item until the evaluation step consumes it
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_take) begin
            r_in_valid <= 1'b1;
        end else if (advance) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_in_data <= i_in.data;
        end
    end

    // result register: load on each step, drop the valid once transferred
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= r_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (step) begin
            r_out_data <= result;
        end
    end

    assign o_out.valid = r_out_valid;
    assign o_out.data  = r_out_data;

    // a stalled input register keeps its item
    `PSL_ASSERT_NEXT(a_in_hold, i_clk, i_rst_n, r_in_valid && !advance, r_in_valid)
    // a loss report leaves the link marked lost for a known sender
    `PSL_ASSERT_NOW(a_lost_flag, i_clk, i_rst_n,
        o_out.valid && (o_out.data.status == ST_LOST),
        o_out.data.link_lost && o_out.data.sender_seen)
    // a restore report clears the lost flag
    `PSL_ASSERT_NOW(a_restore, i_clk, i_rst_n,
        o_out.valid && (o_out.data.status == ST_RESTORED),
        !o_out.data.link_lost && o_out.data.sender_seen)
    // only an accepted ping can report a gap
    `PSL_ASSERT_NOW(a_gap_src, i_clk, i_rst_n,
        o_out.valid && (o_out.data.gap_count != 32'd0),
        (o_out.data.status == ST_ACCEPTED) || (o_out.data.status == ST_RESTORED))
endmodule

// ===== src/psl_cfg_regs.sv =====
// Configuration registers of the packet sequence loss monitor.
module psl_cfg_regs (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic [psl_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [psl_pkg::CFG_W-1:0]      i_cfg_wdata,
    output psl_pkg::t_cfg                  o_cfg
);
    import psl_pkg::*;

    t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.expected_length <= RST_EXPECTED_LENGTH;
            r_cfg.magic_value     <= RST_MAGIC_VALUE;
            r_cfg.timeout_ms      <= RST_TIMEOUT_MS;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_EXPECTED_LENGTH: r_cfg.expected_length <= i_cfg_wdata[7:0];
                CFG_MAGIC_VALUE:     r_cfg.magic_value     <= i_cfg_wdata[7:0];
                CFG_TIMEOUT_MS:      r_cfg.timeout_ms      <= i_cfg_wdata[31:0];
                default: ;
            endcase
        end
    end

    assign o_cfg = r_cfg;
endmodule

// ===== src/psl_core.sv =====
// Monitor state and the per-item evaluation that updates it.
module psl_core (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_step,
    input  psl_pkg::t_in_item  i_item,
    input  psl_pkg::t_cfg      i_cfg,
    output psl_pkg::t_out_item o_result
);
    import psl_pkg::*;

    logic [31:0] r_received, n_received;
    logic [31:0] r_missed, n_missed;
    logic [31:0] r_losses, n_losses;
    logic [31:0] r_prior_seq, n_prior_seq;
    logic [31:0] r_prior_time, n_prior_time;
    logic        r_lost, n_lost;
    logic        r_seen, n_seen;
    logic [47:0] r_mac, n_mac;

    logic [2:0]  status;
    logic [31:0] gap;
    logic [31:0] silence;
    logic [31:0] next_seq;
    logic [31:0] quiet;

    assign next_seq = r_prior_seq + 32'd1;
    assign quiet    = i_item.now_ms - r_prior_time;

    always_comb begin
        n_received   = r_received;
        n_missed     = r_missed;
        n_losses     = r_losses;
        n_prior_seq  = r_prior_seq;
        n_prior_time = r_prior_time;
        n_lost       = r_lost;
        n_seen       = r_seen;
        n_mac        = r_mac;
        status       = ST_NONE;
        gap          = '0;
        silence      = '0;

        case (i_item.opcode)
            OP_PING: begin
                if (i_item.msg_length != i_cfg.expected_length) begin
                    status = ST_BAD_LEN;
                end else if (i_item.magic_byte != i_cfg.magic_value) begin
                    status = ST_BAD_MAGIC;
                end else begin
                    status = ST_ACCEPTED;
                    if (!r_seen) begin
                        n_mac = i_item.source_mac;
                    end
                    if (r_lost) begin
                        silence = quiet;
                        n_lost  = 1'b0;
                        status  = ST_RESTORED;
                    end
                    // only forward jumps count as missed packets
                    if (r_seen && (i_item.sequence_req > next_seq)) begin
                        gap      = i_item.sequence_req - next_seq;
                        n_missed = r_missed + gap;
                    end
                    n_prior_seq  = i_item.sequence_req;
                    n_prior_time = i_item.now_ms;
                    n_received   = r_received + 32'd1;
                    n_seen       = 1'b1;
                end
            end
            OP_TICK: begin
                if (r_seen && !r_lost && (quiet >= i_cfg.timeout_ms)) begin
                    n_lost   = 1'b1;
                    n_losses = r_losses + 32'd1;
                    silence  = quiet;
                    status   = ST_LOST;
                end
            end
            OP_CLEAR: begin
                n_received = '0;
                n_missed   = '0;
                n_losses   = '0;
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_received   <= '0;
            r_missed     <= '0;
            r_losses     <= '0;
            r_prior_seq  <= '0;
            r_prior_time <= '0;
            r_lost       <= 1'b0;
            r_seen       <= 1'b0;
            r_mac        <= '0;
        end else if (i_step) begin
            r_received   <= n_received;
            r_missed     <= n_missed;
            r_losses     <= n_losses;
            r_prior_seq  <= n_prior_seq;
            r_prior_time <= n_prior_time;
            r_lost       <= n_lost;
            r_seen       <= n_seen;
            r_mac        <= n_mac;
        end
    end

    // statistics show the state after this item
    always_comb begin
        o_result.status           = status;
        o_result.gap_count        = gap;
        o_result.silence_ms       = silence;
        o_result.received_total   = n_received;
        o_result.missed_total     = n_missed;
        o_result.loss_event_total = n_losses;
        o_result.latest_sequence  = n_prior_seq;
        o_result.link_lost        = n_lost;
        o_result.sender_seen      = n_seen;
        o_result.sender_mac       = n_mac;
    end
endmodule
